// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define CSSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define CSSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/csss_pkg.sv =====
// Shared constants, types and functions of the case-insensitive substring search.
package csss_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;
  localparam int WIN_DEPTH     = PATTERN_MAX - 1;
  localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
  localparam int IDX_BITS      = $clog2(PATTERN_MAX);
  localparam int PADDR_BITS    = 5;
  localparam int PDATA_BITS    = 64;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [PADDR_BITS-1:0] {
    ADDR_PATTERN_LOW  = 5'd0,
    ADDR_PATTERN_HIGH = 5'd8,
    ADDR_PATTERN_LEN  = 5'd16
  } reg_addr_e;

  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [LEN_BITS-1:0]         length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_t;

  function automatic logic [7:0] fold_byte(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== sv/csss_stream_if.sv =====
// Valid/ready channel interfaces for text bytes and search results.
interface csss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface csss_result_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic        search_done;
  logic [15:0] match_position;

  modport source (output valid, output match_found, output search_done,
                  output match_position, input ready);
  modport sink   (input valid, input match_found, input search_done,
                  input match_position, output ready);
endinterface

// ===== sv/csss_apb_regs.sv =====
// APB register file holding the search pattern and its length.
module csss_apb_regs import csss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [63:0]         pat_lo_q, pat_lo_d;
  logic [63:0]         pat_hi_q, pat_hi_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_d    = len_q;
    if (wr_en) begin
      case (paddr)
        ADDR_PATTERN_LOW:  pat_lo_d = pwdata;
        ADDR_PATTERN_HIGH: pat_hi_d = pwdata;
        ADDR_PATTERN_LEN:  len_d    = pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      len_q    <= len_d;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_PATTERN_LOW:  prdata = pat_lo_q;
      ADDR_PATTERN_HIGH: prdata = pat_hi_q;
      ADDR_PATTERN_LEN:  prdata = PDATA_BITS'(len_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.length  = len_q;

endmodule

// ===== sv/csss_fold_stage.sv =====
// Input register stage: captures a text byte and folds it to lower case.
module csss_fold_stage import csss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  csss_text_if.sink text_i,
  input  logic  take_i,
  output logic  valid_o,
  output text_t item_o
);

  logic  valid_q, valid_d;
  text_t item_q, item_d;
  logic  load;

  assign text_i.ready = !valid_q || take_i;
  assign load         = text_i.valid && text_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d          = 1'b1;
      item_d.text_byte = fold_byte(text_i.text_byte);
      item_d.text_last = text_i.text_last;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/csss_match_core.sv =====
// Window of folded bytes, parallel pattern compare, search state and result register.
module csss_match_core import csss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  text_t item_i,
  output logic  take_o,
  csss_result_if.source result_o
);

  logic [7:0]               win_q [WIN_DEPTH];
  logic [7:0]               win_d [WIN_DEPTH];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     matched_q, matched_d;

  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;
  logic                     done_q, done_d;
  logic [POSITION_BITS-1:0] mpos_q, mpos_d;

  logic [7:0]               pat  [PATTERN_MAX];
  logic [7:0]               cand [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   eq;
  logic [LEN_BITS-1:0]      len_eff;
  logic [LEN_BITS-1:0]      len_m1;
  logic                     cmp_hit;
  logic                     hit;
  logic [POSITION_BITS-1:0] start;

  assign take_o = valid_i && (!out_valid_q || result_o.ready);

  assign len_eff = (cfg_i.length > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                           : cfg_i.length;
  assign len_m1  = len_eff - LEN_BITS'(1);

  assign cand[0] = item_i.text_byte;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    logic [LEN_BITS-1:0] idx;
    assign pat[j] = fold_byte(cfg_i.pattern[j]);
    if (j > 0) begin : g_cand
      assign cand[j] = win_q[j-1];
    end
    assign idx   = len_m1 - LEN_BITS'(j);
    assign eq[j] = (LEN_BITS'(j) >= len_eff) || (cand[idx[IDX_BITS-1:0]] == pat[j]);
  end

  assign cmp_hit = (len_eff == '0) ? (pos_q == '0)
                                   : ((pos_q >= POSITION_BITS'(len_m1)) && (&eq));
  assign hit     = !matched_q && (pos_q != POS_MAX) && cmp_hit;
  assign start   = (len_eff == '0) ? '0 : pos_q - POSITION_BITS'(len_m1);

  always_comb begin
    win_d       = win_q;
    pos_d       = pos_q;
    matched_d   = matched_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    done_d      = done_q;
    mpos_d      = mpos_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      done_d      = hit || item_i.text_last;
      mpos_d      = hit ? start : '0;
      if (item_i.text_last) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_d[i] = '0;
        end
        pos_d     = '0;
        matched_d = 1'b0;
      end else begin
        for (int i = 1; i < WIN_DEPTH; i++) begin
          win_d[i] = win_q[i-1];
        end
        win_d[0]  = item_i.text_byte;
        matched_d = matched_q || hit;
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      pos_q       <= '0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      pos_q       <= pos_d;
      matched_q   <= matched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    done_q  <= done_d;
    mpos_q  <= mpos_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.match_found    = found_q;
  assign result_o.search_done    = done_q;
  assign result_o.match_position = mpos_q;

endmodule

// ===== sv/case_insensitive_substring_search.sv =====
// Case-insensitive search for the first occurrence of a pattern of up to 16 bytes in a
// byte stream. Each text byte yields one result, which may flag a match (with the start
// offset of the match) or the end of the text. A new byte is accepted every clock
// cycle while results are taken. The byte is folded into the input register when it is
// accepted, and the 16-lane window compare then loads the result register from the input
// register when the result side has room. While the result side stalls, the two
// registers fill and the input is held off until a result is taken. Write the pattern
// registers only while no text is in flight.
module case_insensitive_substring_search import csss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csss_text_if.sink             text_i,
  csss_result_if.source         result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  logic  s1_valid;
  text_t s1_item;
  logic  s1_take;

  csss_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csss_fold_stage u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  csss_match_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s1_valid),
    .item_i   (s1_item),
    .take_o   (s1_take),
    .result_o (result_o)
  );

endmodule

// ===== sv/csss_checker.sv =====
// Port-level checker for the substring search, bound to the top level.
`include "assert_macros.svh"

module csss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        match_found,
  input logic        search_done,
  input logic [15:0] match_position,
  input logic        pready
);

  `CSSS_ASSERT(a_found_is_done, out_valid && match_found |-> search_done, "match without done")
  `CSSS_ASSERT(a_pos_zero, out_valid && !match_found |-> match_position == 16'd0, "stray position")
  `CSSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(match_position), "transaction dropped")
  `CSSS_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind case_insensitive_substring_search csss_checker u_csss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (result_o.valid),
  .out_ready      (result_o.ready),
  .match_found    (result_o.match_found),
  .search_done    (result_o.search_done),
  .match_position (result_o.match_position),
  .pready         (pready)
);

// ===== sim/tb.sv =====
// Testbench for the case-insensitive substring search: streamed texts checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TEXT_LOAD   = 70;
  localparam int unsigned SETTINGS_PER_PHASE = 6;
  localparam int unsigned RX_HOLD     = 300;

  typedef struct packed {
    logic                     match_found;
    logic                     search_done;
    logic [POSITION_BITS-1:0] match_position;
  } search_result_t;

  typedef logic [7:0] byte_seq_t [$];

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  csss_text_if   text_if ();
  csss_result_if result_if ();

  case_insensitive_substring_search i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [63:0]              pat_low;
  logic [63:0]              pat_high;
  logic [4:0]               pat_len;
  logic [7:0]               search_window [WIN_DEPTH];
  logic [POSITION_BITS-1:0] text_pos;
  logic                     first_hit_seen;

  text_t          pending_text [$];
  search_result_t expected_results [$];
  bit             text_offered = 1'b0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    rx_hold_cycles = 0;
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] lower_case(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  function automatic logic [7:0] raw_pattern_byte(input int unsigned k);
    logic [127:0] bits;
    bits = {pat_high, pat_low};
    return bits[8*k +: 8];
  endfunction

  function automatic logic [7:0] case_jitter(input logic [7:0] b);
    logic [7:0] l;
    l = lower_case(b);
    if (l >= 8'h61 && l <= 8'h7A && $urandom_range(1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  function automatic logic [7:0] noise_byte(input int unsigned eff);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40 || eff == 0) begin
      return 8'($urandom_range(255));
    end
    if (pick < 75) begin
      return case_jitter(raw_pattern_byte($urandom_range(eff - 1)));
    end
    return case_jitter(8'(8'h61 + $urandom_range(2)));
  endfunction

  task automatic predict_search(input text_t item);
    logic [7:0]               cur;
    int unsigned              len;
    int unsigned              k;
    logic                     hit;
    logic [POSITION_BITS-1:0] start;
    search_result_t           res;
    cur   = lower_case(item.text_byte);
    len   = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    hit   = 1'b0;
    start = '0;
    if (!first_hit_seen && text_pos != POS_MAX) begin
      if (len == 0) begin
        hit = (text_pos == 0);
      end else if (text_pos >= len - 1) begin
        hit = (cur == lower_case(raw_pattern_byte(len - 1)));
        for (k = 0; k + 1 < len; k++) begin
          if (search_window[len - 2 - k] != lower_case(raw_pattern_byte(k))) begin
            hit = 1'b0;
          end
        end
        start = text_pos - POSITION_BITS'(len - 1);
      end
    end
    res.match_found    = hit;
    res.search_done    = hit || item.text_last;
    res.match_position = hit ? start : '0;
    expected_results.push_back(res);
    if (item.text_last) begin
      search_window  = '{default: '0};
      text_pos       = '0;
      first_hit_seen = 1'b0;
    end else begin
      if (hit) begin
        first_hit_seen = 1'b1;
      end
      for (k = WIN_DEPTH - 1; k > 0; k--) begin
        search_window[k] = search_window[k-1];
      end
      search_window[0] = cur;
      if (text_pos != POS_MAX) begin
        text_pos++;
      end
    end
  endtask

  task automatic queue_text(input byte_seq_t bytes);
    foreach (bytes[i]) begin
      pending_text.push_back(text_t'{text_byte: bytes[i], text_last: (i == bytes.size() - 1)});
    end
  endtask

  task automatic write_register(input reg_addr_e which, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= which;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    case (which)
      ADDR_PATTERN_LOW:  pat_low  = value;
      ADDR_PATTERN_HIGH: pat_high = value;
      ADDR_PATTERN_LEN:  pat_len  = value[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_text.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_random_pattern();
    logic [127:0] bits;
    int unsigned  pick;
    int unsigned  k;
    int unsigned  len;
    for (k = 0; k < PATTERN_MAX; k++) begin
      pick = $urandom_range(99);
      bits[8*k +: 8] = (pick < 60) ? case_jitter(8'(8'h61 + $urandom_range(2)))
                                   : 8'($urandom_range(255));
    end
    pick = $urandom_range(99);
    len  = (pick < 10) ? 0 : (pick < 20) ? PATTERN_MAX :
           (pick < 30) ? $urandom_range(17, 31) : $urandom_range(1, PATTERN_MAX - 1);
    write_register(ADDR_PATTERN_LOW, bits[63:0]);
    write_register(ADDR_PATTERN_HIGH, bits[127:64]);
    write_register(ADDR_PATTERN_LEN, 64'(len));
  endtask

  task automatic queue_random_text(output int unsigned count);
    byte_seq_t   txt;
    int unsigned eff;
    int unsigned shape;
    int unsigned cut;
    int unsigned k;
    bit          truncate;
    eff   = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    shape = $urandom_range(99);
    repeat (($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12)) begin
      txt.push_back(noise_byte(eff));
    end
    if (shape < 65) begin
      repeat ($urandom_range(1, 2)) begin
        for (k = 0; k < eff; k++) begin
          txt.push_back(case_jitter(raw_pattern_byte(k)));
        end
        repeat ($urandom_range(0, 3)) txt.push_back(noise_byte(eff));
      end
    end else if (shape < 85) begin
      // aim to break the occurrence: cut it short or flip one bit
      cut      = $urandom_range(0, eff);
      truncate = 1'($urandom_range(1));
      for (k = 0; k < eff && !(truncate && k == cut); k++) begin
        txt.push_back((k == cut) ? raw_pattern_byte(k) ^ (8'h01 << $urandom_range(7))
                                 : case_jitter(raw_pattern_byte(k)));
      end
    end
    repeat ($urandom_range(0, 6)) txt.push_back(noise_byte(eff));
    if (txt.size() == 0) begin
      txt.push_back(noise_byte(eff));
    end
    queue_text(txt);
    count = txt.size();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !text_offered && pending_text.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      text_if.valid     <= 1'b1;
      text_if.text_byte <= pending_text[0].text_byte;
      text_if.text_last <= pending_text[0].text_last;
      text_offered = 1'b1;
    end else if (!text_offered) begin
      text_if.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && text_if.valid && text_if.ready) begin
      predict_search(pending_text.pop_front());
      text_offered = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_cycles != 0) begin
      result_if.ready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      result_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_if.match_found !== want.match_found) begin
          $error("match_found: expected %0d, actual %0d", want.match_found,
                 result_if.match_found);
          fail_count++;
        end
        if (result_if.search_done !== want.search_done) begin
          $error("search_done: expected %0d, actual %0d", want.search_done,
                 result_if.search_done);
          fail_count++;
        end
        if (result_if.match_position !== want.match_position) begin
          $error("match_position: expected %0d, actual %0d", want.match_position,
                 result_if.match_position);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned setting;
    int unsigned queued;
    int unsigned n;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    text_if.text_last = 1'b0;
    result_if.ready   = 1'b0;
    pat_low           = '0;
    pat_high          = '0;
    pat_len           = '0;
    search_window     = '{default: '0};
    text_pos          = '0;
    first_hit_seen    = 1'b0;
    send_idle_pct     = 27;
    recv_idle_pct     = 66;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty pattern straight out of reset
    queue_text('{8'h71, 8'h52});
    wait_until_drained();
    // letters at the fold limits next to the neighbors that must not fold
    write_register(ADDR_PATTERN_LOW, 64'h0000_0000_5B40_7A41);
    write_register(ADDR_PATTERN_LEN, 4);
    queue_text('{8'h78, 8'h61, 8'h5A, 8'h40, 8'h5B, 8'h41});
    queue_text('{8'h61, 8'h5A, 8'h60, 8'h7B});
    queue_text('{8'h41});
    wait_until_drained();
    // zero bytes as data; the cleared window must not match
    write_register(ADDR_PATTERN_LOW, 64'h0);
    write_register(ADDR_PATTERN_LEN, 3);
    queue_text('{8'h00, 8'h00});
    queue_text('{8'h00, 8'h00, 8'h00});
    queue_text('{8'hFF});

    for (phase = 0; phase < 3; phase++) begin
      for (setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
        wait_until_drained();
        case (phase)
          0: begin
            send_idle_pct = 27;
            recv_idle_pct = 66;
          end
          1: begin
            send_idle_pct = 66;
            recv_idle_pct = 27;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        if (setting == 0) begin
          case (phase)
            0: begin
              write_register(ADDR_PATTERN_LOW, '1);
              write_register(ADDR_PATTERN_HIGH, '1);
              write_register(ADDR_PATTERN_LEN, PATTERN_MAX);
            end
            1: begin
              load_random_pattern();
              write_register(ADDR_PATTERN_LEN, 31);
            end
            default: begin
              load_random_pattern();
              write_register(ADDR_PATTERN_LEN, 17);
              @(posedge clk_i);
              rx_hold_cycles = RX_HOLD;
            end
          endcase
        end else begin
          load_random_pattern();
        end
        queued = 0;
        while (queued < TEXT_LOAD) begin
          queue_random_text(n);
          queued += n;
        end
      end
    end

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/csss_pkg.sv
sv/csss_stream_if.sv
sv/csss_apb_regs.sv
sv/csss_fold_stage.sv
sv/csss_match_core.sv
sv/case_insensitive_substring_search.sv
sv/csss_checker.sv
sim/tb.sv
